// ===== rtl/core/tkrs_pkg.sv =====
// Shared types and constants for the top-K running sum unit.
package tkrs_pkg;

   localparam int DATA_W            = 32;
   localparam int SUM_W             = 42;
   localparam int CNT_OUT_W         = 11;
   localparam int DEF_HEAP_CAPACITY = 1024;

   localparam logic [CNT_OUT_W-1:0] KEEP_LIMIT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_UP,
      ST_UP_CMP,
      ST_DN,
      ST_DN_CMP,
      ST_FIN
   } state_type;

endpackage

// ===== rtl/core/top_k_running_sum_unit.sv =====
// Top level: keeps the K largest samples in a min-heap and their running sum.
//
// Usage: present a sample on req_sample_value and pulse start while busy is
// low; the sample is taken at that edge and busy rises. Exactly one result
// beat follows, shown for a single cycle with rsp_valid high: the running
// sum, the smallest kept value (zero while nothing is kept), the kept count
// and whether the sample entered the set. busy falls after that cycle.
// A rejected sample goes straight to the result beat. An insert climbs the
// heap from the new leaf, and a replacement of the minimum first subtracts
// the old minimum and then descends from the root; either writes the value
// once it settles, and the result beat follows.
// Each level costs one memory read (both children at once on the way down)
// and one compare in a compare-and-move step; the 42-bit adder is
// shared between adding the new sample and removing the old minimum.
// The receiver cannot stall: every result is delivered in its cycle.
// csr_keep_limit sets K and is written whenever csr_valid is high; write it
// only while busy is low. Reset empties the set, clears the sum and sets K
// to 1024; heap memory is not cleared, since only live entries are read.
module top_k_running_sum_unit
   import tkrs_pkg::*;
#(
   parameter int HEAP_CAPACITY = DEF_HEAP_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DATA_W-1:0]    req_sample_value,
   output logic                        rsp_valid,
   output logic signed [SUM_W-1:0]     rsp_kept_sum,
   output logic signed [DATA_W-1:0]   rsp_smallest_kept,
   output logic [CNT_OUT_W-1:0]        rsp_kept_count,
   output logic                        rsp_value_taken,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CNT_OUT_W-1:0]        csr_keep_limit
);

   localparam int AW  = $clog2(HEAP_CAPACITY);
   localparam int CW  = $clog2(HEAP_CAPACITY + 1);
   localparam int CIW = AW + 2;
   localparam int LW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

   state_type state_ff, state_in;

   logic [CNT_OUT_W-1:0]     keep_limit_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] root_ff, root_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic                     taken_ff, taken_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic signed [DATA_W-1:0] rd_data_a;
   logic signed [DATA_W-1:0] rd_data_b;

   logic                     accept;
   logic                     do_insert;
   logic                     do_replace;
   logic [LW-1:0]            count_lw;
   logic [AW-1:0]            parent;
   logic [CIW-1:0]           left_idx;
   logic [CIW-1:0]           right_idx;
   logic [CIW-1:0]           count_ci;
   logic                     left_ok;
   logic                     right_ok;

   logic                     add_neg;
   logic signed [DATA_W-1:0] add_opnd;
   logic [SUM_W-1:0]         add_ext;
   logic signed [SUM_W-1:0]  add_res;

   tkrs_heap_ram #(
      .DEPTH (HEAP_CAPACITY),
      .AW    (AW)
   ) u_heap (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign count_lw = LW'(count_ff);

   // A limit above capacity behaves as the capacity.
   assign do_insert  = (count_lw < LW'(keep_limit_ff)) && (count_lw < LW'(HEAP_CAPACITY));
   assign do_replace = !do_insert && (count_ff != '0) && (root_ff < req_sample_value);

   assign parent    = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + CIW'(1);
   assign count_ci  = CIW'(count_ff);
   assign left_ok   = left_idx < count_ci;
   assign right_ok  = right_idx < count_ci;

   // Shared 42-bit adder: adds the new sample, or subtracts the old minimum.
   assign add_neg  = (state_ff == ST_SUB);
   assign add_opnd = add_neg ? root_ff : req_sample_value;
   assign add_ext  = {{(SUM_W-DATA_W){add_opnd[DATA_W-1]}}, add_opnd};
   assign add_res  = sum_ff + (add_neg ? ~add_ext : add_ext) + SUM_W'(add_neg);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (do_insert) begin
                  state_in = ST_UP;
               end else if (do_replace) begin
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SUB: begin
            state_in = ST_DN;
         end
         ST_UP: begin
            state_in = (pos_ff == '0) ? ST_FIN : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = (val_ff < rd_data_a) ? ST_UP : ST_FIN;
         end
         ST_DN: begin
            state_in = left_ok ? ST_DN_CMP : ST_FIN;
         end
         ST_DN_CMP: begin
            if ((rd_data_a < val_ff) || (right_ok && (rd_data_b < val_ff))) begin
               state_in = ST_DN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      val_in    = val_ff;
      pos_in    = pos_ff;
      taken_in  = taken_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;
      rd_addr_a = parent;
      rd_addr_b = parent;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in   = req_sample_value;
               taken_in = do_insert || do_replace;
               if (do_insert) begin
                  count_in = count_ff + CW'(1);
                  pos_in   = count_ff[AW-1:0];
                  sum_in   = add_res;
               end else if (do_replace) begin
                  pos_in = '0;
                  sum_in = add_res;
               end
            end
         end
         ST_SUB: begin
            sum_in = add_res;
         end
         ST_UP: begin
            // The new value travels up as a hole; it is stored once it settles.
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (val_ff < rd_data_a) begin
               wr_data = rd_data_a;
               pos_in  = parent;
            end
         end
         ST_DN: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_ok ? right_idx[AW-1:0] : left_idx[AW-1:0];
            if (!left_ok) begin
               wr_en = 1'b1;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            // Ties keep the left child, and a child equal to the value stays put.
            if (right_ok && (rd_data_b < rd_data_a) && (rd_data_b < val_ff)) begin
               wr_data = rd_data_b;
               pos_in  = right_idx[AW-1:0];
            end else if (rd_data_a < val_ff) begin
               wr_data = rd_data_a;
               pos_in  = left_idx[AW-1:0];
            end
         end
         ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   assign root_in = (wr_en && (wr_addr == '0)) ? wr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keep_limit_ff <= KEEP_LIMIT_RESET;
         count_ff      <= '0;
         sum_ff        <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (csr_valid) begin
            keep_limit_ff <= csr_keep_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      root_ff  <= root_in;
      val_ff   <= val_in;
      pos_ff   <= pos_in;
      taken_ff <= taken_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = (state_ff == ST_FIN);
   assign rsp_kept_sum      = sum_ff;
   assign rsp_smallest_kept = (count_ff == '0) ? '0 : root_ff;
   assign rsp_kept_count    = count_lw[CNT_OUT_W-1:0];
   assign rsp_value_taken   = taken_ff;

endmodule

// ===== rtl/core/tkrs_heap_ram.sv =====
// Heap storage: one write port and two registered read ports.
module tkrs_heap_ram
   import tkrs_pkg::*;
#(
   parameter int DEPTH = DEF_HEAP_CAPACITY,
   parameter int AW    = $clog2(DEF_HEAP_CAPACITY)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   output logic signed [DATA_W-1:0] rd_data_a,
   output logic signed [DATA_W-1:0] rd_data_b
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_a_ff;
   logic signed [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/core/tkrs_checker.sv =====
// Port-level checks for the top-K running sum unit, bound to the top level.
module tkrs_checker
   import tkrs_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic signed [DATA_W-1:0]  rsp_smallest_kept,
   input logic [CNT_OUT_W-1:0]      rsp_kept_count
);

   // A result beat lasts one cycle and is never back to back.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted sample");

   a_result_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat shown while idle");

   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kept_count == '0)) |-> (rsp_smallest_kept == '0))
      else $error("smallest kept value not zero with an empty set");

endmodule

bind top_k_running_sum_unit tkrs_checker u_tkrs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_smallest_kept (rsp_smallest_kept),
   .rsp_kept_count    (rsp_kept_count)
);
